### hw/rtl/timed_waypoint_setpoint_player_core_defines.svh
// Assertion helpers shared by the player RTL.
`ifndef TIMED_WAYPOINT_SETPOINT_PLAYER_CORE_DEFINES_SVH
`define TIMED_WAYPOINT_SETPOINT_PLAYER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/twsp_pkg.sv
package twsp_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VEL_W       = 48;
	localparam int STAMP_W     = 31;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// request codes on item.req_type
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_DATA  = 2'd1;
	localparam logic [1:0] REQ_EXEC  = 2'd2;
	localparam logic [1:0] REQ_TICK  = 2'd3;

	// result kinds
	localparam logic [2:0] K_ACCEPT   = 3'd0;
	localparam logic [2:0] K_STALE    = 3'd1;
	localparam logic [2:0] K_IGNORED  = 3'd2;
	localparam logic [2:0] K_SETPOINT = 3'd3;
	localparam logic [2:0] K_END      = 3'd4;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_DATA,
		OP_EXEC,
		OP_TICK
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_END2
	} state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] turn_rate;
		logic [30:0]        stamp_us;
	} item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] set_vx;
		logic signed [15:0] set_vy;
		logic signed [15:0] set_turn;
		logic               last_flag;
	} res_t;

	// queued command: vel packs vx low, vy middle, turn high
	typedef struct packed {
		op_t                op;
		logic [VEL_W-1:0]   vel;
		logic [STAMP_W-1:0] stamp;
	} cmd_t;

endpackage

### hw/rtl/twsp_ram.sv
module twsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/twsp_front.sv
`include "timed_waypoint_setpoint_player_core_defines.svh"

module twsp_front import twsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	output logic  busy,
	output logic  q_valid,
	output cmd_t  q_head,
	input  logic  q_ready
);

	cmd_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	cmd_t              cmd_in;

	// request code -> command
	always_comb begin
		cmd_in.vel   = {item.turn_rate, item.vel_y, item.vel_x};
		cmd_in.stamp = item.stamp_us;
		unique case (item.req_type)
			REQ_CLEAR: cmd_in.op = OP_CLEAR;
			REQ_DATA:  cmd_in.op = OP_DATA;
			REQ_EXEC:  cmd_in.op = OP_EXEC;
			REQ_TICK:  cmd_in.op = OP_TICK;
			default:   cmd_in.op = OP_TICK;
		endcase
	end

	assign busy    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign pop     = q_valid && q_ready;
	assign q_head  = q_mem[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	`TWSP_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`TWSP_ASSERT_NXT(a_cnt_push, clk, arst_n, push && !pop,
		cnt_q == $past(cnt_q) + QCNT_W'(1), "push lost")

endmodule

### hw/rtl/twsp_back.sv
`include "timed_waypoint_setpoint_player_core_defines.svh"

module twsp_back import twsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_head,
	output logic q_ready,
	output logic strobe,
	output res_t result
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   entry_count_q, entry_count_d;
	logic [STAMP_W-1:0] prev_stamp_q, prev_stamp_d;
	logic               playing_q, playing_d;
	logic [IDX_W-1:0]   play_index_q, play_index_d;
	logic [STAMP_W-1:0] time_left_q, time_left_d;
	logic [VEL_W-1:0]   cur_vel_q, cur_vel_d;
	logic [IDX_W-1:0]   enter_idx_q, enter_idx_d;
	res_t               result_q, result_d;
	logic               strobe_q, strobe_d;

	logic               pop;
	logic               full;
	logic               enter_req;
	logic [CNT_W-1:0]   enter_idx;
	logic               need_read;
	logic               last_hit;

	logic               vel_we;
	logic               dur_we;
	logic [IDX_W-1:0]   vel_waddr;
	logic [IDX_W-1:0]   dur_waddr;
	logic [STAMP_W-1:0] dur_wdata;
	logic [IDX_W-1:0]   rd_addr;
	logic [VEL_W-1:0]   vel_rdata;
	logic [STAMP_W-1:0] dur_rdata;

	twsp_ram #(.WIDTH(VEL_W), .DEPTH(TABLE_DEPTH)) u_vel_ram (
		.clk   (clk),
		.we    (vel_we),
		.waddr (vel_waddr),
		.wdata (q_head.vel),
		.raddr (rd_addr),
		.rdata (vel_rdata)
	);

	twsp_ram #(.WIDTH(STAMP_W), .DEPTH(TABLE_DEPTH)) u_dur_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (dur_waddr),
		.wdata (dur_wdata),
		.raddr (rd_addr),
		.rdata (dur_rdata)
	);

	assign q_ready   = (state_q == ST_IDLE);
	assign pop       = q_valid && q_ready;
	assign full      = (entry_count_q == CNT_W'(TABLE_DEPTH));
	assign enter_idx = playing_q ? CNT_W'(play_index_q) + CNT_W'(1) : '0;
	assign enter_req = playing_q ? (q_head.op == OP_TICK && time_left_q <= STAMP_W'(1))
	                             : (full || q_head.op == OP_EXEC);
	assign need_read = pop && enter_req && (enter_idx < entry_count_q);
	assign rd_addr   = enter_idx[IDX_W-1:0];
	assign last_hit  = (CNT_W'(enter_idx_q) == entry_count_q - CNT_W'(1));

	assign vel_waddr = entry_count_q[IDX_W-1:0];
	assign dur_waddr = IDX_W'(entry_count_q - CNT_W'(1));
	assign dur_wdata = q_head.stamp - prev_stamp_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (need_read) begin
				state_d = ST_READ;
			end
			ST_READ: state_d = last_hit ? ST_END2 : ST_IDLE;
			ST_END2: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and results
	always_comb begin
		entry_count_d = entry_count_q;
		prev_stamp_d  = prev_stamp_q;
		playing_d     = playing_q;
		play_index_d  = play_index_q;
		time_left_d   = time_left_q;
		cur_vel_d     = cur_vel_q;
		enter_idx_d   = enter_idx_q;
		result_d      = result_q;
		strobe_d      = 1'b0;
		vel_we        = 1'b0;
		dur_we        = 1'b0;

		unique case (state_q)
			ST_IDLE: if (pop) begin
				enter_idx_d = enter_idx[IDX_W-1:0];
				result_d    = '{kind: K_ACCEPT, set_vx: '0, set_vy: '0, set_turn: '0,
				                last_flag: 1'b1};
				if (enter_req) begin
					if (!need_read) begin
						// ran past the table end: path over
						playing_d     = 1'b0;
						entry_count_d = '0;
						play_index_d  = '0;
						time_left_d   = '0;
						result_d.kind = K_END;
						strobe_d      = 1'b1;
					end
				end else if (playing_q) begin
					if (q_head.op == OP_TICK) begin
						time_left_d = time_left_q - STAMP_W'(1);
					end else begin
						result_d.kind     = K_IGNORED;
						result_d.set_vx   = cur_vel_q[15:0];
						result_d.set_vy   = cur_vel_q[31:16];
						result_d.set_turn = cur_vel_q[47:32];
						strobe_d          = 1'b1;
					end
				end else begin
					unique case (q_head.op)
						OP_CLEAR: begin
							entry_count_d = '0;
							strobe_d      = 1'b1;
						end
						OP_DATA: begin
							strobe_d = 1'b1;
							if (entry_count_q != '0 && q_head.stamp <= prev_stamp_q) begin
								result_d.kind = K_STALE;
							end else begin
								dur_we        = (entry_count_q != '0);
								vel_we        = 1'b1;
								prev_stamp_d  = q_head.stamp;
								entry_count_d = entry_count_q + CNT_W'(1);
							end
						end
						default: begin
							// idle tick: no result
						end
					endcase
				end
			end
			ST_READ: begin
				playing_d         = 1'b1;
				play_index_d      = enter_idx_q;
				cur_vel_d         = vel_rdata;
				time_left_d       = dur_rdata;
				result_d.kind     = K_SETPOINT;
				result_d.set_vx   = vel_rdata[15:0];
				result_d.set_vy   = vel_rdata[31:16];
				result_d.set_turn = vel_rdata[47:32];
				result_d.last_flag = !last_hit;
				strobe_d          = 1'b1;
			end
			ST_END2: begin
				playing_d     = 1'b0;
				entry_count_d = '0;
				play_index_d  = '0;
				time_left_d   = '0;
				result_d      = '{kind: K_END, set_vx: '0, set_vy: '0, set_turn: '0,
				                  last_flag: 1'b1};
				strobe_d      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cur_vel_q   <= cur_vel_d;
		enter_idx_q <= enter_idx_d;
		result_q    <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			prev_stamp_q  <= '0;
			playing_q     <= 1'b0;
			play_index_q  <= '0;
			time_left_q   <= '0;
			strobe_q      <= 1'b0;
		end else begin
			state_q       <= state_d;
			entry_count_q <= entry_count_d;
			prev_stamp_q  <= prev_stamp_d;
			playing_q     <= playing_d;
			play_index_q  <= play_index_d;
			time_left_q   <= time_left_d;
			strobe_q      <= strobe_d;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`TWSP_ASSERT_NXT(a_end_follows, clk, arst_n, state_q == ST_END2,
		strobe_q && result_q.kind == K_END && result_q.last_flag, "path end not emitted")
	`TWSP_ASSERT_IMP(a_play_in_table, clk, arst_n, playing_q,
		CNT_W'(play_index_q) < entry_count_q, "playing outside table")

endmodule

### hw/rtl/timed_waypoint_setpoint_player_core.sv
// Timed waypoint setpoint player. Load waypoints (three Q8.8 velocities plus a
// start stamp in us) with data transactions, then execute: each entry's
// setpoint is emitted and held for the gap to the next stamp, counted in tick
// transactions, and passing the last entry ends the path and empties the table.
// A transaction is taken when start is high and busy is low. A two-entry
// command queue sits between the accept side and the executor, so busy only
// rises when both slots are taken. Results come out one per strobe cycle and
// the receiver cannot stall them: sample result whenever strobe is high.
// In the executor, clear, data, stale, ignored and tick transactions are
// handled in the idle state; starting a table entry passes through a read
// state, since the velocity and duration tables are synchronous-read RAMs;
// the final entry also passes through an end state, as its setpoint and the
// path-end result leave on consecutive cycles.
// The tables are not cleared after reset; only entries below the fill count
// are ever read, so no init sweep is needed.
module timed_waypoint_setpoint_player_core import twsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	output logic  busy,
	output logic  strobe,
	output res_t  result
);

	// front -> back command queue head
	logic q_valid;
	logic q_ready;
	cmd_t q_head;

	twsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.busy    (busy),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_ready (q_ready)
	);

	// executor: table RAMs, playback timer, registered result
	twsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_ready (q_ready),
		.strobe  (strobe),
		.result  (result)
	);

endmodule
